// ===== sv/ovle_pkg.sv =====
package ovle_pkg;

  localparam int unsigned LIT_W    = 56;
  localparam int unsigned BODY_W   = 64;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned IMM_W    = 2;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned NBYTES   = BODY_W / 8;
  localparam int unsigned DIGIT_W  = 7;

  // Command codes.
  localparam logic CMD_FORM28 = 1'b0;
  localparam logic CMD_FORM56 = 1'b1;

  // Length class codes carried in header bits 3 to 4.
  localparam logic [CLASS_W-1:0] CLS_0 = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_1 = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_2 = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_3 = 2'd3;

  typedef struct packed {
    logic [HDR_W-1:0]  header;
    logic [BODY_W-1:0] body;
    logic [LEN_W-1:0]  length;
    logic              range_error;
  } result_t;

endpackage

// ===== sv/ovle_encode.sv =====
module ovle_encode (
  input  logic                            command,
  input  logic [ovle_pkg::OPCODE_W-1:0]   opcode,
  input  logic [ovle_pkg::IMM_W-1:0]      small_imm,
  input  logic [ovle_pkg::LIT_W-1:0]      literal,
  output ovle_pkg::result_t               res
);

  logic [ovle_pkg::BODY_W-1:0]  spread;
  logic [ovle_pkg::BODY_W-1:0]  mask;
  logic [ovle_pkg::CLASS_W-1:0] cls;
  logic [ovle_pkg::LEN_W-1:0]   nbody;
  logic                         err;
  logic                         lit_zero;
  logic                         lt_2p7;
  logic                         lt_2p13;
  logic                         lt_2p14;
  logic                         lt_2p28;

  // Each body byte holds seven literal bits under a set marker bit.
  always_comb begin
    for (int i = 0; i < ovle_pkg::NBYTES; i++) begin
      spread[8*i +: 8] = {1'b1, literal[ovle_pkg::DIGIT_W*i +: ovle_pkg::DIGIT_W]};
    end
  end

  assign lit_zero = (literal == '0);
  assign lt_2p7   = (literal[ovle_pkg::LIT_W-1:7] == '0);
  assign lt_2p13  = (literal[ovle_pkg::LIT_W-1:13] == '0);
  assign lt_2p14  = (literal[ovle_pkg::LIT_W-1:14] == '0);
  assign lt_2p28  = (literal[ovle_pkg::LIT_W-1:28] == '0);

  always_comb begin
    err = 1'b0;
    case (command)
      ovle_pkg::CMD_FORM28: begin
        err = !lt_2p28;
        if (lit_zero) begin
          cls = ovle_pkg::CLS_0; nbody = 4'd0;
        end else if (lt_2p7) begin
          cls = ovle_pkg::CLS_1; nbody = 4'd1;
        end else if (lt_2p13) begin
          cls = ovle_pkg::CLS_2; nbody = 4'd2;
        end else begin
          cls = ovle_pkg::CLS_3; nbody = 4'd4;
        end
      end
      ovle_pkg::CMD_FORM56: begin
        if (lt_2p7) begin
          cls = ovle_pkg::CLS_0; nbody = 4'd1;
        end else if (lt_2p14) begin
          cls = ovle_pkg::CLS_1; nbody = 4'd2;
        end else if (lt_2p28) begin
          cls = ovle_pkg::CLS_2; nbody = 4'd4;
        end else begin
          cls = ovle_pkg::CLS_3; nbody = 4'd8;
        end
      end
      default: begin
        cls = ovle_pkg::CLS_0; nbody = 4'd0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < ovle_pkg::NBYTES; i++) begin
      mask[8*i +: 8] = {8{ovle_pkg::LEN_W'(i) < nbody}};
    end
  end

  always_comb begin
    if (err) begin
      res.header      = '0;
      res.body        = '0;
      res.length      = '0;
      res.range_error = 1'b1;
    end else begin
      res.header      = {1'b0, small_imm, cls, opcode};
      res.body        = spread & mask;
      res.length      = nbody + 4'd1;
      res.range_error = 1'b0;
    end
  end

endmodule

// ===== sv/opcode_varint_literal_encoder.sv =====
// Opcode and varint literal encoder.
//
// An item enters on the command channel: command, opcode, small_imm and
// literal are taken at a rising clock edge where start is high and busy is
// low. The block packs them into one header byte and up to eight radix-128
// body bytes, each body byte carrying seven literal bits with its top bit set.
// Command 0 selects the 28-bit form, command 1 the 56-bit form. A literal too
// wide for the 28-bit form gives range_error with all other fields zero.
//
// The result shows on header, body, length and range_error for exactly one
// cycle, marked by done, after the item has passed the input register and
// the result register. There is one input register and one result register
// with a single pass of compare and bit-scatter logic between them, so an
// item can be taken every cycle and a result leaves every cycle. The
// receiver cannot stall the block; busy is high only while reset is applied.
//
// Reset (rst, synchronous) drops any items in flight: done stays low until
// a new item has passed both registers.
module opcode_varint_literal_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [ovle_pkg::OPCODE_W-1:0] opcode,
  input  logic [ovle_pkg::IMM_W-1:0]    small_imm,
  input  logic [ovle_pkg::LIT_W-1:0]    literal,
  output logic                          done,
  output logic [ovle_pkg::HDR_W-1:0]    header,
  output logic [ovle_pkg::BODY_W-1:0]   body,
  output logic [ovle_pkg::LEN_W-1:0]    length,
  output logic                          range_error
);

  // Input register stage.
  logic                          in_valid;
  logic                          in_command;
  logic [ovle_pkg::OPCODE_W-1:0] in_opcode;
  logic [ovle_pkg::IMM_W-1:0]    in_imm;
  logic [ovle_pkg::LIT_W-1:0]    in_literal;

  // Result register stage.
  ovle_pkg::result_t result;
  ovle_pkg::result_t result_next;

  logic accept;

  // The block never holds off items except while reset is applied.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_command <= command;
      in_opcode  <= opcode;
      in_imm     <= small_imm;
      in_literal <= literal;
    end
  end

  ovle_encode u_encode (
    .command   (in_command),
    .opcode    (in_opcode),
    .small_imm (in_imm),
    .literal   (in_literal),
    .res       (result_next)
  );

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

  assign header      = result.header;
  assign body        = result.body;
  assign length      = result.length;
  assign range_error = result.range_error;

endmodule

// ===== sv/ovle_checker.sv =====
module ovle_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [ovle_pkg::HDR_W-1:0]    header,
  input logic [ovle_pkg::BODY_W-1:0]   body,
  input logic [ovle_pkg::LEN_W-1:0]    length,
  input logic                          range_error
);

  // Every accepted item yields a result once it has passed both register stages.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  // No result appears without an item taken through both register stages.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !done)
    else $error("result without an accepted item");

  // An out-of-range result carries nothing else.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (header == '0 && body == '0 && length == '0))
    else $error("range error result has nonzero fields");

  // A good result has a legal byte count, a clear header top bit and a consistent first body byte.
  a_length_legal: assert property (@(posedge clk) disable iff (rst)
    (done && !range_error) |->
      ((length == 4'd1 || length == 4'd2 || length == 4'd3 || length == 4'd5 ||
        length == 4'd9) && header[7] == 1'b0 && body[7] == (length != 4'd1)))
    else $error("inconsistent result length or markers");

endmodule

bind opcode_varint_literal_encoder ovle_checker u_ovle_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for the opcode and varint literal encoder.
//
// Each item carries a command (28-bit or 56-bit form), an opcode, a 2-bit
// immediate and a 56-bit literal. The bench keeps its own encoder function
// that computes the header, the radix-128 body, the byte count and the range
// flag for each item taken by the block. Those results wait in a queue until
// the block strobes done. The block has no configuration and no state, so the
// test tasks only differ in the literals they pick and in how often the
// sender pauses between items.
module testbench;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  // The block holds an item for two register stages, so a few cycles after
  // the last result are enough to catch any stray strobe.
  localparam int DRAIN_CYCLES = 8;
  // This is many times the longest sender pause.
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          command;
  logic [ovle_pkg::OPCODE_W-1:0] opcode;
  logic [ovle_pkg::IMM_W-1:0]    small_imm;
  logic [ovle_pkg::LIT_W-1:0]    literal;
  logic                          done;
  logic [ovle_pkg::HDR_W-1:0]    header;
  logic [ovle_pkg::BODY_W-1:0]   body;
  logic [ovle_pkg::LEN_W-1:0]    length;
  logic                          range_error;

  // Encodings computed for items taken by the block, oldest first.
  ovle_pkg::result_t pending_encodings[$];

  int mismatch_count = 0;
  int compared_count = 0;
  int form28_count   = 0;
  int form56_count   = 0;
  int overflow_count = 0;
  int stall_cycles   = 0;

  // Chance in percent that the sender pauses after an item.
  int idle_pct = 0;

  always #CLK_HALF clk = ~clk;

  opcode_varint_literal_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .opcode      (opcode),
    .small_imm   (small_imm),
    .literal     (literal),
    .done        (done),
    .header      (header),
    .body        (body),
    .length      (length),
    .range_error (range_error)
  );

  // Computes the expected result for one item. The body is every 7-bit digit
  // of the literal with bit 7 set, cut down to the number of bytes that the
  // length class calls for.
  function automatic ovle_pkg::result_t encode_literal(
      input logic cmd,
      input logic [ovle_pkg::OPCODE_W-1:0] op,
      input logic [ovle_pkg::IMM_W-1:0] imm,
      input logic [ovle_pkg::LIT_W-1:0] lit);
    ovle_pkg::result_t            enc;
    int unsigned                  nbits;
    int unsigned                  nbody;
    logic [ovle_pkg::CLASS_W-1:0] cls;
    logic [ovle_pkg::BODY_W-1:0]  digits;
    enc   = '0;
    nbits = 0;
    for (int i = 0; i < ovle_pkg::LIT_W; i++) begin
      if (lit[i]) nbits = i + 1;
    end
    if (cmd == ovle_pkg::CMD_FORM28) begin
      // Anything at or above 2^28 does not fit: only the flag is raised.
      if (nbits > 28) begin
        enc.range_error = 1'b1;
        return enc;
      end
      if (nbits == 0) begin
        cls = ovle_pkg::CLS_0; nbody = 0;
      end else if (nbits <= 7) begin
        cls = ovle_pkg::CLS_1; nbody = 1;
      end else if (nbits <= 13) begin
        cls = ovle_pkg::CLS_2; nbody = 2;
      end else begin
        cls = ovle_pkg::CLS_3; nbody = 4;
      end
    end else begin
      // The 56-bit form always emits at least one body byte, even for zero.
      if (nbits <= 7) begin
        cls = ovle_pkg::CLS_0; nbody = 1;
      end else if (nbits <= 14) begin
        cls = ovle_pkg::CLS_1; nbody = 2;
      end else if (nbits <= 28) begin
        cls = ovle_pkg::CLS_2; nbody = 4;
      end else begin
        cls = ovle_pkg::CLS_3; nbody = 8;
      end
    end
    for (int b = 0; b < ovle_pkg::NBYTES; b++) begin
      digits[8*b +: 8] = (b < nbody) ?
        {1'b1, lit[ovle_pkg::DIGIT_W*b +: ovle_pkg::DIGIT_W]} : 8'h00;
    end
    enc.header = {1'b0, imm, cls, op};
    enc.body   = digits;
    enc.length = ovle_pkg::LEN_W'(nbody + 1);
    return enc;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s differs: expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Records each item the block takes and checks each result it strobes.
  // Both happen at the rising edge, so the values read here are the ones that
  // were stable during the cycle that this edge ends.
  always @(posedge clk) begin
    ovle_pkg::result_t want;
    if (start && !busy) begin
      want = encode_literal(command, opcode, small_imm, literal);
      pending_encodings.push_back(want);
      if (command == ovle_pkg::CMD_FORM28) form28_count++;
      else form56_count++;
      if (want.range_error) overflow_count++;
    end
    if (!rst && done) begin
      if (pending_encodings.size() == 0) begin
        report_mismatch("unexpected result, header", 64'd0, 64'(header));
      end else begin
        want = pending_encodings.pop_front();
        compared_count++;
        if (header !== want.header) begin
          report_mismatch("header", 64'(want.header), 64'(header));
        end
        if (body !== want.body) report_mismatch("body", want.body, body);
        if (length !== want.length) begin
          report_mismatch("length", 64'(want.length), 64'(length));
        end
        if (range_error !== want.range_error) begin
          report_mismatch("range_error", 64'(want.range_error), 64'(range_error));
        end
      end
    end
    // The watchdog only counts cycles in which neither side moves anything.
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  // Presents one item and holds it until the block takes it. Afterwards the
  // sender may pause, by the chance in idle_pct: mostly for a few cycles, now
  // and then for a long stretch. When there is no pause, start simply stays
  // high so the next item follows on the very next cycle.
  task automatic send_item(input logic cmd, input logic [ovle_pkg::OPCODE_W-1:0] op,
                           input logic [ovle_pkg::IMM_W-1:0] imm,
                           input logic [ovle_pkg::LIT_W-1:0] lit);
    int gap;
    start     <= 1'b1;
    command   <= cmd;
    opcode    <= op;
    small_imm <= imm;
    literal   <= lit;
    do @(posedge clk); while (busy !== 1'b0);
    gap = 0;
    if ($urandom_range(99, 0) < idle_pct) begin
      if ($urandom_range(9, 0) != 0) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 8);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A random item whose literal has a random bit length, so every length
  // class and its edges get hit. In the 28-bit form most literals fit; about
  // one in ten is drawn from the full literal width and may be too wide.
  task automatic send_random_item();
    logic                       cmd;
    int unsigned                nbits;
    logic [63:0]                raw;
    logic [ovle_pkg::LIT_W-1:0] lit;
    cmd = 1'($urandom_range(1, 0));
    if (cmd == ovle_pkg::CMD_FORM28 && $urandom_range(9, 0) != 0) begin
      nbits = $urandom_range(28, 0);
    end else begin
      nbits = $urandom_range(ovle_pkg::LIT_W, 0);
    end
    raw = {$urandom, $urandom};
    lit = raw[ovle_pkg::LIT_W-1:0];
    if (nbits == 0) begin
      lit = '0;
    end else begin
      lit = lit & ((ovle_pkg::LIT_W'(1) << nbits) - ovle_pkg::LIT_W'(1));
      lit[nbits-1] = 1'b1;
    end
    send_item(cmd, ovle_pkg::OPCODE_W'($urandom_range(7, 0)),
              ovle_pkg::IMM_W'($urandom_range(3, 0)), lit);
  endtask

  // Edges of the 28-bit form: zero with no body, the one-byte class, the
  // 13-bit and 28-bit limits, and literals just past the form's range,
  // including the widest literal the port can carry.
  task automatic test_form28_boundaries();
    logic [ovle_pkg::LIT_W-1:0] points[9] = '{
      56'd0, 56'd1, 56'd127, 56'd128, 56'h1FFF, 56'h2000,
      56'hFFF_FFFF, 56'h1000_0000, 56'hFF_FFFF_FFFF_FFFF
    };
    idle_pct = 30;
    for (int i = 0; i < 9; i++) begin
      send_item(ovle_pkg::CMD_FORM28, ovle_pkg::OPCODE_W'(i), ovle_pkg::IMM_W'(i),
                points[i]);
    end
  endtask

  // Edges of the 56-bit form: zero still takes one body byte, the 7, 14 and
  // 28-bit class limits, the full 56-bit literal, and alternating patterns
  // so each literal bit is seen both set and clear in the widest class.
  task automatic test_form56_boundaries();
    logic [ovle_pkg::LIT_W-1:0] points[10] = '{
      56'd0, 56'd127, 56'd128, 56'h3FFF, 56'h4000, 56'hFFF_FFFF,
      56'h1000_0000, 56'hFF_FFFF_FFFF_FFFF, 56'h55_5555_5555_5555,
      56'hAA_AAAA_AAAA_AAAA
    };
    idle_pct = 30;
    for (int i = 0; i < 10; i++) begin
      send_item(ovle_pkg::CMD_FORM56, ovle_pkg::OPCODE_W'(7 - i),
                ovle_pkg::IMM_W'(3 - i), points[i]);
    end
  endtask

  // Random items at full rate, one per cycle with no pauses.
  task automatic test_random_streaming();
    idle_pct = 0;
    repeat (120) send_random_item();
  endtask

  // Random items with pauses after a good share of them.
  task automatic test_random_with_gaps();
    idle_pct = 40;
    repeat (330) send_random_item();
  endtask

  // Random items sent mostly one at a time, so that the pipeline empties out
  // between them.
  task automatic test_random_sparse();
    idle_pct = 90;
    repeat (100) send_random_item();
  endtask

  // Ends the run if nothing moves for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Watchdog: no item or result for %0d cycles, %0d results still expected",
             STALL_LIMIT, pending_encodings.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    command   <= ovle_pkg::CMD_FORM28;
    opcode    <= '0;
    small_imm <= '0;
    literal   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_form28_boundaries();
    test_form56_boundaries();
    test_random_streaming();
    test_random_with_gaps();
    test_random_sparse();

    start <= 1'b0;
    while (pending_encodings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d items in the 28-bit form (%0d too wide)", form28_count,
             overflow_count);
    $display("and %0d in the 56-bit form; checked %0d results, %0d mismatches found.",
             form56_count, compared_count, mismatch_count);
    if (mismatch_count == 0 && pending_encodings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
